// ===== hdl/escd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the epoch seconds to calendar date converter.
package escd_pkg;

    localparam int PIPE_DEPTH = 6;

    typedef logic [8:0] yday_t;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic                  in_stall;
        logic                  out_valid;
    } pipe_ctrl_t;

endpackage

// ===== hdl/escd_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// Stage occupancy and load enables for the converter pipeline.
module escd_pipe_ctrl
    import escd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_stall,
    output pipe_ctrl_t ctrl
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] load;

    // a stage may load when empty or when the stage after it moves on
    always_comb
    begin
        load[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || !out_stall;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load      = load;
    assign ctrl.in_stall  = !load[0];
    assign ctrl.out_valid = valid_reg[PIPE_DEPTH-1];

endmodule

// ===== hdl/escd_month_walk.sv =====
`timescale 1ns / 1ps
// Month and day of month from day of year, by compare against month start days.
module escd_month_walk
    import escd_pkg::*;
(
    input  yday_t       yday,
    input  logic        leap,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month
);

    localparam logic [11:0][8:0] START_COMMON = {
        9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
        9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
    };
    localparam logic [11:0][8:0] START_LEAP = {
        9'd335, 9'd305, 9'd274, 9'd244, 9'd213, 9'd182,
        9'd152, 9'd121, 9'd91,  9'd60,  9'd31,  9'd0
    };

    logic [11:0][8:0] start;
    logic [3:0]       cnt;
    yday_t            offset;

    always_comb
    begin
        start = leap ? START_LEAP : START_COMMON;
        cnt   = '0;
        for (int i = 1; i < 12; i++)
        begin
            if (yday >= start[i])
            begin
                cnt = cnt + 4'd1;
            end
        end
        offset = yday - start[cnt];
    end

    assign month        = cnt;
    assign day_of_month = offset[4:0] + 5'd1;

endmodule

// ===== hdl/epoch_seconds_to_calendar_date.sv =====
`timescale 1ns / 1ps
// Top level: pipelined conversion of a signed epoch second count to a UTC calendar date.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+---------------------------------------------
//  epoch in | epoch_valid | epoch_stall | epoch_seconds
//  date out | date_valid  | date_stall  | valid_res, second .. day_of_year
//
// Six register stages: one beat enters per cycle while epoch_stall is low.
// Latency is set by the chain of reciprocal multiplies (per day, per 4-year period,
// per minute, per hour) and the month compare, one stage each.
// Reset clears only the stage valid bits. A stall at the output holds the full stages;
// empty stages still fill, so epoch_stall rises only once every stage is occupied.
module epoch_seconds_to_calendar_date
    import escd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              epoch_valid,
    output logic              epoch_stall,
    input  logic signed [31:0] epoch_seconds,
    output logic              date_valid,
    input  logic              date_stall,
    output logic              valid_res,
    output logic [5:0]        second,
    output logic [5:0]        minute,
    output logic [4:0]        hour,
    output logic [4:0]        day_of_month,
    output logic [3:0]        month,
    output logic [7:0]        years_since_1900,
    output logic [2:0]        weekday,
    output logic [8:0]        day_of_year
);

    localparam logic [24:0] DAY_RECIP   = 25'd25451659;   // 2^34 / 675
    localparam logic [15:0] QUAD_RECIP  = 16'd45934;      // 2^26 / 1461
    localparam logic [15:0] WEEK_RECIP  = 16'd37450;      // 2^18 / 7
    localparam logic [17:0] MIN_RECIP   = 18'd139811;     // 2^23 / 60
    localparam logic [11:0] HOUR_RECIP  = 12'd2185;       // 2^17 / 60
    localparam logic [7:0]  BASE_YEAR   = 8'd70;
    localparam logic [10:0] END_YEAR1   = 11'd365;
    localparam logic [10:0] END_YEAR2   = 11'd730;
    localparam logic [10:0] END_YEAR3   = 11'd1096;
    localparam logic [14:0] EPOCH_WDAY  = 15'd4;

    pipe_ctrl_t ctrl;

    escd_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (epoch_valid),
        .out_stall (date_stall),
        .ctrl      (ctrl)
    );

    assign epoch_stall = ctrl.in_stall;
    assign date_valid  = ctrl.out_valid;

    // stage A: input register
    logic [30:0] a_t_reg;
    logic        a_neg_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            a_t_reg   <= epoch_seconds[30:0];
            a_neg_reg <= epoch_seconds[31];
        end
    end

    // stage B: day count, t / 86400 = (t >> 7) / 675
    logic [48:0] b_prod;
    logic [14:0] b_days_reg;
    logic [16:0] b_tlo_reg;
    logic        b_neg_reg;

    assign b_prod = 49'(a_t_reg[30:7]) * 49'(DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            b_days_reg <= b_prod[48:34];
            b_tlo_reg  <= a_t_reg[16:0];
            b_neg_reg  <= a_neg_reg;
        end
    end

    // stage C: seconds of day, 4-year period, weekday
    logic [31:0] c_day_secs;
    logic [16:0] c_sod;
    logic [30:0] c_qprod;
    logic [14:0] c_d4;
    logic [30:0] c_wprod;
    logic [12:0] c_q7;
    logic [14:0] c_wrem;
    logic [16:0] c_sod_reg;
    logic [14:0] c_days_reg;
    logic [4:0]  c_quad_reg;
    logic [2:0]  c_wday_reg;
    logic        c_neg_reg;

    assign c_day_secs = 32'(b_days_reg) * 32'd86400;
    assign c_sod      = b_tlo_reg - c_day_secs[16:0];
    assign c_qprod    = 31'(b_days_reg) * 31'(QUAD_RECIP);
    assign c_d4       = b_days_reg + EPOCH_WDAY;
    assign c_wprod    = 31'(c_d4) * 31'(WEEK_RECIP);
    assign c_q7       = c_wprod[30:18];
    assign c_wrem     = c_d4 - 15'(c_q7) * 15'd7;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            c_sod_reg  <= c_sod;
            c_days_reg <= b_days_reg;
            c_quad_reg <= c_qprod[30:26];
            c_wday_reg <= c_wrem[2:0];
            c_neg_reg  <= b_neg_reg;
        end
    end

    // stage D: day within period, minutes of day, second
    logic [14:0] d_rem;
    logic [34:0] d_mprod;
    logic [10:0] d_mins;
    logic [16:0] d_srem;
    logic [10:0] d_rem_reg;
    logic [10:0] d_mins_reg;
    logic [5:0]  d_sec_reg;
    logic [4:0]  d_quad_reg;
    logic [2:0]  d_wday_reg;
    logic        d_neg_reg;

    assign d_rem   = c_days_reg - 15'(c_quad_reg) * 15'd1461;
    assign d_mprod = 35'(c_sod_reg) * 35'(MIN_RECIP);
    assign d_mins  = d_mprod[33:23];
    assign d_srem  = c_sod_reg - 17'(d_mins) * 17'd60;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            d_rem_reg  <= d_rem[10:0];
            d_mins_reg <= d_mins;
            d_sec_reg  <= d_srem[5:0];
            d_quad_reg <= c_quad_reg;
            d_wday_reg <= c_wday_reg;
            d_neg_reg  <= c_neg_reg;
        end
    end

    // stage E: year and day of year, hour and minute
    logic [1:0]  e_yoff;
    logic [10:0] e_yday;
    logic        e_leap;
    logic [22:0] e_hprod;
    logic [4:0]  e_hour;
    logic [10:0] e_mrem;
    logic [7:0]  e_year_reg;
    yday_t       e_yday_reg;
    logic        e_leap_reg;
    logic [4:0]  e_hour_reg;
    logic [5:0]  e_min_reg;
    logic [5:0]  e_sec_reg;
    logic [2:0]  e_wday_reg;
    logic        e_neg_reg;

    // the third year of each period is the leap year
    always_comb
    begin
        e_leap = 1'b0;
        if (d_rem_reg < END_YEAR1)
        begin
            e_yoff = 2'd0;
            e_yday = d_rem_reg;
        end
        else if (d_rem_reg < END_YEAR2)
        begin
            e_yoff = 2'd1;
            e_yday = d_rem_reg - END_YEAR1;
        end
        else if (d_rem_reg < END_YEAR3)
        begin
            e_yoff = 2'd2;
            e_yday = d_rem_reg - END_YEAR2;
            e_leap = 1'b1;
        end
        else
        begin
            e_yoff = 2'd3;
            e_yday = d_rem_reg - END_YEAR3;
        end
    end

    assign e_hprod = 23'(d_mins_reg) * 23'(HOUR_RECIP);
    assign e_hour  = e_hprod[21:17];
    assign e_mrem  = d_mins_reg - 11'(e_hour) * 11'd60;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            e_year_reg <= 8'({d_quad_reg, 2'b00}) + BASE_YEAR + 8'(e_yoff);
            e_yday_reg <= e_yday[8:0];
            e_leap_reg <= e_leap;
            e_hour_reg <= e_hour;
            e_min_reg  <= e_mrem[5:0];
            e_sec_reg  <= d_sec_reg;
            e_wday_reg <= d_wday_reg;
            e_neg_reg  <= d_neg_reg;
        end
    end

    // stage F: month walk and result register
    logic [3:0] f_month;
    logic [4:0] f_mday;

    escd_month_walk u_month
    (
        .yday         (e_yday_reg),
        .leap         (e_leap_reg),
        .month        (f_month),
        .day_of_month (f_mday)
    );

    logic       f_valid_reg;
    logic [5:0] f_sec_reg;
    logic [5:0] f_min_reg;
    logic [4:0] f_hour_reg;
    logic [4:0] f_mday_reg;
    logic [3:0] f_month_reg;
    logic [7:0] f_year_reg;
    logic [2:0] f_wday_reg;
    yday_t      f_yday_reg;

    // negative input: every field zero
    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            if (e_neg_reg)
            begin
                f_valid_reg <= 1'b0;
                f_sec_reg   <= '0;
                f_min_reg   <= '0;
                f_hour_reg  <= '0;
                f_mday_reg  <= '0;
                f_month_reg <= '0;
                f_year_reg  <= '0;
                f_wday_reg  <= '0;
                f_yday_reg  <= '0;
            end
            else
            begin
                f_valid_reg <= 1'b1;
                f_sec_reg   <= e_sec_reg;
                f_min_reg   <= e_min_reg;
                f_hour_reg  <= e_hour_reg;
                f_mday_reg  <= f_mday;
                f_month_reg <= f_month;
                f_year_reg  <= e_year_reg;
                f_wday_reg  <= e_wday_reg;
                f_yday_reg  <= e_yday_reg;
            end
        end
    end

    assign valid_res        = f_valid_reg;
    assign second           = f_sec_reg;
    assign minute           = f_min_reg;
    assign hour             = f_hour_reg;
    assign day_of_month     = f_mday_reg;
    assign month            = f_month_reg;
    assign years_since_1900 = f_year_reg;
    assign weekday          = f_wday_reg;
    assign day_of_year      = f_yday_reg;

endmodule
